/* src/i2c_master_bit_sequencer_unit_assert.svh */
// ----------------------------------------------------------------------------
// I2C bit sequencer assertion macros
// Implication checks sampled on the rising clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define I2CMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cms assertion failed");

// next-cycle implication
`define I2CMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cms assertion failed");

`endif

/* src/i2cms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, codes and helpers of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] SETUP_RST   = 8'd4;
  localparam logic [7:0] HALF_RST    = 8'd2;
  localparam logic [9:0] TIMEOUT_RST = 10'd250;

  localparam logic [1:0] CFG_SETUP   = 2'd0;
  localparam logic [1:0] CFG_HALF    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_ACK   = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_ACK   = 3'd4,
    CMD_READ  = 3'd5
  } cmd_t;

  typedef enum logic [13:0] {
    PH_IDLE   = 14'b00000000000001,
    PH_ST_A   = 14'b00000000000010,
    PH_ST_B   = 14'b00000000000100,
    PH_SP_A   = 14'b00000000001000,
    PH_SP_B   = 14'b00000000010000,
    PH_W_LOW  = 14'b00000000100000,
    PH_W_HIGH = 14'b00000001000000,
    PH_W_HOLD = 14'b00000010000000,
    PH_A_REL  = 14'b00000100000000,
    PH_A_POLL = 14'b00001000000000,
    PH_R_LOW  = 14'b00010000000000,
    PH_R_HIGH = 14'b00100000000000,
    PH_K_LOW  = 14'b01000000000000,
    PH_K_HIGH = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic [7:0] setup_ticks;
    logic [7:0] half_bit_ticks;
    logic [9:0] ack_timeout;
  } cfg_regs_t;

  // a length of zero runs as one tick
  function automatic logic [9:0] len_of(input logic [7:0] n);
    len_of = (n == 8'd0) ? 10'd1 : {2'b00, n};
  endfunction

endpackage

/* src/i2cms_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_front
// Decodes the function code of an incoming item into a command class.
// ----------------------------------------------------------------------------
module i2cms_front (
  input  logic [2:0]      func,
  input  logic [7:0]      tx_byte,
  input  logic            send_ack,
  input  logic            sda_level,
  output i2cms_pkg::item_t item
);

  i2cms_pkg::cmd_t cmd;

  always_comb begin
    case (func)
      i2cms_pkg::FUNC_START: cmd = i2cms_pkg::CMD_START;
      i2cms_pkg::FUNC_STOP:  cmd = i2cms_pkg::CMD_STOP;
      i2cms_pkg::FUNC_WRITE: cmd = i2cms_pkg::CMD_WRITE;
      i2cms_pkg::FUNC_ACK:   cmd = i2cms_pkg::CMD_ACK;
      i2cms_pkg::FUNC_READ:  cmd = i2cms_pkg::CMD_READ;
      default:               cmd = i2cms_pkg::CMD_TICK;
    endcase
  end

  assign item.cmd       = cmd;
  assign item.tx_byte   = tx_byte;
  assign item.send_ack  = send_ack;
  assign item.sda_level = sda_level;

endmodule

/* src/i2cms_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_queue
// Short register queue between the decoder and the sequencer.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_sequencer_unit_assert.svh"

module i2cms_queue #(
  parameter int DEPTH = i2cms_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  i2cms_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output i2cms_pkg::item_t head_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  i2cms_pkg::item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `I2CMS_ASSERT_IMP(a_no_push_full, clk, rst_n, full, !push)
  `I2CMS_ASSERT_IMP(a_no_pop_empty, clk, rst_n, !head_valid, !pop)
  `I2CMS_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))

endmodule

/* src/i2cms_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_back
// Phase sequencer: one queued tick per cycle unless stalled, line state kept as result.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_sequencer_unit_assert.svh"

module i2cms_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cms_pkg::cfg_regs_t cfg,
  input  logic                 q_valid,
  input  i2cms_pkg::item_t     q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 scl_level,
  output logic                 sda_drive,
  output logic                 sda_out,
  output logic                 busy_res,
  output logic                 done_res,
  output logic [7:0]           rx_byte,
  output logic                 ack_failed
);

  i2cms_pkg::phase_t phase_r, phase_nxt;
  i2cms_pkg::cmd_t   active_r, active_nxt;
  logic [9:0] timer_r, timer_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [3:0] bit_inc;
  logic [7:0] shift_r, shift_nxt;
  logic       ack_choice_r, ack_choice_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       drive_r, drive_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       fail_r, fail_nxt;
  logic       done_r, done_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       step;

  assign step    = q_valid && (!out_valid_r || out_ready);
  assign q_pop   = step;
  assign bit_inc = bit_cnt_r + 4'd1;

  always_comb begin
    phase_nxt      = phase_r;
    active_nxt     = active_r;
    timer_nxt      = timer_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    drive_nxt      = drive_r;
    rx_nxt         = rx_r;
    fail_nxt       = fail_r;
    done_nxt       = 1'b0;

    if (phase_r == i2cms_pkg::PH_IDLE) begin
      if (q_item.cmd != i2cms_pkg::CMD_TICK) begin
        active_nxt  = q_item.cmd;
        fail_nxt    = 1'b0;
        bit_cnt_nxt = 4'd0;
      end
      case (q_item.cmd)
        i2cms_pkg::CMD_START: begin
          drive_nxt = 1'b1;
          sda_nxt   = 1'b1;
          scl_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_ST_A;
          timer_nxt = i2cms_pkg::len_of(cfg.setup_ticks);
        end
        i2cms_pkg::CMD_STOP: begin
          drive_nxt = 1'b1;
          sda_nxt   = 1'b0;
          scl_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_SP_A;
          timer_nxt = i2cms_pkg::len_of(cfg.setup_ticks);
        end
        i2cms_pkg::CMD_WRITE: begin
          scl_nxt   = 1'b0;
          drive_nxt = 1'b1;
          sda_nxt   = q_item.tx_byte[7];
          shift_nxt = {q_item.tx_byte[6:0], 1'b0};
          phase_nxt = i2cms_pkg::PH_W_LOW;
          timer_nxt = i2cms_pkg::len_of(cfg.half_bit_ticks);
        end
        i2cms_pkg::CMD_ACK: begin
          drive_nxt = 1'b0;
          sda_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_A_REL;
          timer_nxt = i2cms_pkg::len_of(cfg.half_bit_ticks);
        end
        i2cms_pkg::CMD_READ: begin
          drive_nxt      = 1'b0;
          sda_nxt        = 1'b1;
          scl_nxt        = 1'b0;
          shift_nxt      = 8'd0;
          ack_choice_nxt = q_item.send_ack;
          phase_nxt      = i2cms_pkg::PH_R_LOW;
          timer_nxt      = i2cms_pkg::len_of(cfg.half_bit_ticks);
        end
        default: begin
        end
      endcase
    end else if (phase_r == i2cms_pkg::PH_A_POLL) begin
      if (!q_item.sda_level) begin
        scl_nxt   = 1'b0;
        phase_nxt = i2cms_pkg::PH_IDLE;
        done_nxt  = 1'b1;
      end else if (timer_r >= cfg.ack_timeout) begin
        drive_nxt = 1'b1;
        scl_nxt   = 1'b0;
        sda_nxt   = 1'b0;
        phase_nxt = i2cms_pkg::PH_SP_A;
        timer_nxt = i2cms_pkg::len_of(cfg.setup_ticks);
      end else begin
        timer_nxt = timer_r + 10'd1;
      end
    end else if (timer_r > 10'd1) begin
      timer_nxt = timer_r - 10'd1;
    end else begin
      case (phase_r)
        i2cms_pkg::PH_ST_A: begin
          sda_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_ST_B;
          timer_nxt = i2cms_pkg::len_of(cfg.setup_ticks);
        end
        i2cms_pkg::PH_ST_B: begin
          scl_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_IDLE;
          done_nxt  = 1'b1;
        end
        i2cms_pkg::PH_SP_A: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_SP_B;
          timer_nxt = i2cms_pkg::len_of(cfg.setup_ticks);
        end
        i2cms_pkg::PH_SP_B: begin
          if (active_r == i2cms_pkg::CMD_ACK) begin
            fail_nxt = 1'b1;
          end
          phase_nxt = i2cms_pkg::PH_IDLE;
          done_nxt  = 1'b1;
        end
        i2cms_pkg::PH_W_LOW: begin
          scl_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_W_HIGH;
          timer_nxt = i2cms_pkg::len_of(cfg.half_bit_ticks);
        end
        i2cms_pkg::PH_W_HIGH: begin
          scl_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_W_HOLD;
          timer_nxt = i2cms_pkg::len_of(cfg.half_bit_ticks);
        end
        i2cms_pkg::PH_W_HOLD: begin
          bit_cnt_nxt = bit_inc;
          if (bit_inc[3]) begin
            phase_nxt = i2cms_pkg::PH_IDLE;
            done_nxt  = 1'b1;
          end else begin
            drive_nxt = 1'b1;
            sda_nxt   = shift_r[7];
            shift_nxt = {shift_r[6:0], 1'b0};
            phase_nxt = i2cms_pkg::PH_W_LOW;
            timer_nxt = i2cms_pkg::len_of(cfg.half_bit_ticks);
          end
        end
        i2cms_pkg::PH_A_REL: begin
          scl_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_A_POLL;
          timer_nxt = 10'd0;
        end
        i2cms_pkg::PH_R_LOW: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], q_item.sda_level};
          phase_nxt = i2cms_pkg::PH_R_HIGH;
          timer_nxt = i2cms_pkg::len_of(cfg.half_bit_ticks);
        end
        i2cms_pkg::PH_R_HIGH: begin
          scl_nxt     = 1'b0;
          bit_cnt_nxt = bit_inc;
          timer_nxt   = i2cms_pkg::len_of(cfg.half_bit_ticks);
          if (bit_inc[3]) begin
            rx_nxt    = shift_r;
            drive_nxt = 1'b1;
            sda_nxt   = !ack_choice_r;
            phase_nxt = i2cms_pkg::PH_K_LOW;
          end else begin
            phase_nxt = i2cms_pkg::PH_R_LOW;
          end
        end
        i2cms_pkg::PH_K_LOW: begin
          scl_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_K_HIGH;
          timer_nxt = i2cms_pkg::len_of(cfg.half_bit_ticks);
        end
        i2cms_pkg::PH_K_HIGH: begin
          scl_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_IDLE;
          done_nxt  = 1'b1;
        end
        default: begin
          phase_nxt = i2cms_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cms_pkg::PH_IDLE;
      active_r     <= i2cms_pkg::CMD_TICK;
      timer_r      <= 10'd0;
      bit_cnt_r    <= 4'd0;
      shift_r      <= 8'd0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      drive_r      <= 1'b1;
      rx_r         <= 8'd0;
      fail_r       <= 1'b0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        phase_r      <= phase_nxt;
        active_r     <= active_nxt;
        timer_r      <= timer_nxt;
        bit_cnt_r    <= bit_cnt_nxt;
        shift_r      <= shift_nxt;
        ack_choice_r <= ack_choice_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        drive_r      <= drive_nxt;
        rx_r         <= rx_nxt;
        fail_r       <= fail_nxt;
        done_r       <= done_nxt;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign scl_level  = scl_r;
  assign sda_drive  = drive_r;
  assign sda_out    = sda_r;
  assign busy_res   = (phase_r != i2cms_pkg::PH_IDLE);
  assign done_res   = done_r;
  assign rx_byte    = rx_r;
  assign ack_failed = fail_r;

  `I2CMS_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, phase_r == i2cms_pkg::PH_IDLE)
  `I2CMS_ASSERT_IMP(a_fail_done, clk, rst_n, $rose(fail_r), done_r)
  `I2CMS_ASSERT_IMP(a_write_drives, clk, rst_n,
    phase_r == i2cms_pkg::PH_W_LOW || phase_r == i2cms_pkg::PH_W_HIGH, drive_r)
  `I2CMS_ASSERT_NXT(a_hold_on_stall, clk, rst_n, out_valid_r && !out_ready,
    $stable(phase_r) && $stable(timer_r))

endmodule

/* src/i2c_master_bit_sequencer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// I2C master at the bit level, advanced by one tick item per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one tick item per accept; in_func selects start, stop, write,
//            wait-ack or read while idle and is ignored while busy.
//   out_*  : one result item per tick: line levels, busy, done pulse,
//            last received byte and the ack failure flag.
//   cfg_*  : register writes (0 setup ticks, 1 half-bit ticks, 2 ack
//            timeout), always ready; write only while the block is idle.
// Path: an accepted tick item is held in the decode queue, then its result is
//   registered in the sequencer register and presented from there.
// Throughput: one item per cycle, set by the phase update; output stalls hold it.
// Reset: registers return to 4 / 2 / 250, lines idle high, SDA driven, queue
//   and output empty.
// Receiver stall: the result register holds; the queue absorbs up to
//   QDEPTH more items, then in_ready drops.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit #(
  parameter int QDEPTH = i2cms_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_func,
  input  logic [7:0] in_tx_byte,
  input  logic       in_send_ack,
  input  logic       in_sda_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_drive,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_rx_byte,
  output logic       out_ack_failed,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  i2cms_pkg::cfg_regs_t cfg_r;
  i2cms_pkg::item_t     dec_item;
  i2cms_pkg::item_t     head_item;
  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setup_ticks    <= i2cms_pkg::SETUP_RST;
      cfg_r.half_bit_ticks <= i2cms_pkg::HALF_RST;
      cfg_r.ack_timeout    <= i2cms_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        i2cms_pkg::CFG_SETUP:   cfg_r.setup_ticks    <= cfg_data[7:0];
        i2cms_pkg::CFG_HALF:    cfg_r.half_bit_ticks <= cfg_data[7:0];
        i2cms_pkg::CFG_TIMEOUT: cfg_r.ack_timeout    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  i2cms_front u_front (
    .func      (in_func),
    .tx_byte   (in_tx_byte),
    .send_ack  (in_send_ack),
    .sda_level (in_sda_level),
    .item      (dec_item)
  );

  i2cms_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (dec_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  i2cms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .scl_level  (out_scl_level),
    .sda_drive  (out_sda_drive),
    .sda_out    (out_sda_out),
    .busy_res   (out_busy_res),
    .done_res   (out_done_res),
    .rx_byte    (out_rx_byte),
    .ack_failed (out_ack_failed)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master bit sequencer.
// Every tick item sent to the block is also run through a bench-side model of
// the sequencer. Its line levels, busy, done, received byte and ack failure
// (fixed for some directed rows) are queued and compared field by field with
// each result item. A directed list comes first, then random bus transactions
// (start, address, ack, data, stop) under several register settings and
// flow-control mixes, including a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cms_pkg::*;

  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;

  localparam int SDA_LOW         = 0;
  localparam int SDA_HIGH        = 1;
  localparam int SDA_RAND        = 2;
  localparam int SDA_MOSTLY_HIGH = 3;

  localparam int RAND_BUDGET = 70;
  localparam int HOLD_CYCLES = 80;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic       scl;
    logic       drv;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       fail;
  } levels_t;

  localparam levels_t LV_RESET    = '{scl: 1'b1, drv: 1'b1, sda: 1'b1, busy: 1'b0,
                                      done: 1'b0, rx: 8'h00, fail: 1'b0};
  localparam levels_t LV_START    = '{scl: 1'b1, drv: 1'b1, sda: 1'b1, busy: 1'b1,
                                      done: 1'b0, rx: 8'h00, fail: 1'b0};
  localparam levels_t LV_ACK_FAIL = '{scl: 1'b1, drv: 1'b1, sda: 1'b1, busy: 1'b0,
                                      done: 1'b0, rx: 8'h00, fail: 1'b1};

  typedef struct {
    logic [2:0] f;
    logic [7:0] tx;
    logic       ack;
    int         sda_mode;
    bit         typed;
    levels_t    lv;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_func = '0;
  logic [7:0] in_tx_byte = '0;
  logic       in_send_ack = 1'b0;
  logic       in_sda_level = 1'b1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_scl_level;
  logic       out_sda_drive;
  logic       out_sda_out;
  logic       out_busy_res;
  logic       out_done_res;
  logic [7:0] out_rx_byte;
  logic       out_ack_failed;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  // sequencer model state and register copy
  phase_t     seq_ph;
  cmd_t       seq_cmd;
  logic [9:0] seq_tmr;
  logic [3:0] seq_bits;
  logic [7:0] seq_shift;
  logic       seq_ack_sel;
  logic       seq_scl;
  logic       seq_sda;
  logic       seq_drv;
  logic [7:0] seq_rx;
  logic       seq_fail;
  logic [7:0] reg_setup;
  logic [7:0] reg_half;
  logic [9:0] reg_timeout;

  levels_t  levels_q[$];
  dir_row_t dir_rows[19];

  int n_errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cmd_slots = 0;
  int n_ack_fails = 0;
  int n_settings = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  i2c_master_bit_sequencer_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_tx_byte     (in_tx_byte),
    .in_send_ack    (in_send_ack),
    .in_sda_level   (in_sda_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_scl_level  (out_scl_level),
    .out_sda_drive  (out_sda_drive),
    .out_sda_out    (out_sda_out),
    .out_busy_res   (out_busy_res),
    .out_done_res   (out_done_res),
    .out_rx_byte    (out_rx_byte),
    .out_ack_failed (out_ack_failed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void enter_phase(input phase_t p, input logic [7:0] n);
    seq_ph  = p;
    seq_tmr = (n == 8'd0) ? 10'd1 : {2'b00, n};
  endfunction

  function automatic void shift_out_bit();
    seq_drv   = 1'b1;
    seq_sda   = seq_shift[7];
    seq_shift = {seq_shift[6:0], 1'b0};
    enter_phase(PH_W_LOW, reg_half);
  endfunction

  // advance the sequencer by one tick and return the line levels after it
  function automatic levels_t tick_levels(input logic [2:0] f, input logic [7:0] tx,
                                          input logic ack, input logic sda_in);
    levels_t lv;
    logic    fin;
    fin = 1'b0;
    if (seq_ph == PH_IDLE) begin
      n_cmd_slots++;
      if (f >= FUNC_START && f <= FUNC_READ) begin
        seq_cmd  = cmd_t'(f);
        seq_fail = 1'b0;
        seq_bits = 4'd0;
        case (seq_cmd)
          CMD_START: begin
            seq_drv = 1'b1;
            seq_sda = 1'b1;
            seq_scl = 1'b1;
            enter_phase(PH_ST_A, reg_setup);
          end
          CMD_STOP: begin
            seq_drv = 1'b1;
            seq_scl = 1'b0;
            seq_sda = 1'b0;
            enter_phase(PH_SP_A, reg_setup);
          end
          CMD_WRITE: begin
            seq_scl   = 1'b0;
            seq_shift = tx;
            shift_out_bit();
          end
          CMD_ACK: begin
            seq_drv = 1'b0;
            seq_sda = 1'b1;
            enter_phase(PH_A_REL, reg_half);
          end
          default: begin
            seq_drv     = 1'b0;
            seq_sda     = 1'b1;
            seq_scl     = 1'b0;
            seq_shift   = 8'h00;
            seq_ack_sel = ack;
            enter_phase(PH_R_LOW, reg_half);
          end
        endcase
      end
    end else if (seq_ph == PH_A_POLL) begin
      if (!sda_in) begin
        seq_scl = 1'b0;
        seq_ph  = PH_IDLE;
        fin     = 1'b1;
      end else if (seq_tmr >= reg_timeout) begin
        seq_drv = 1'b1;
        seq_scl = 1'b0;
        seq_sda = 1'b0;
        enter_phase(PH_SP_A, reg_setup);
      end else begin
        seq_tmr = seq_tmr + 10'd1;
      end
    end else if (seq_tmr > 10'd1) begin
      seq_tmr = seq_tmr - 10'd1;
    end else begin
      case (seq_ph)
        PH_ST_A: begin
          seq_sda = 1'b0;
          enter_phase(PH_ST_B, reg_setup);
        end
        PH_ST_B: begin
          seq_scl = 1'b0;
          seq_ph  = PH_IDLE;
          fin     = 1'b1;
        end
        PH_SP_A: begin
          seq_scl = 1'b1;
          seq_sda = 1'b1;
          enter_phase(PH_SP_B, reg_setup);
        end
        PH_SP_B: begin
          if (seq_cmd == CMD_ACK) begin
            seq_fail = 1'b1;
            n_ack_fails++;
          end
          seq_ph = PH_IDLE;
          fin    = 1'b1;
        end
        PH_W_LOW: begin
          seq_scl = 1'b1;
          enter_phase(PH_W_HIGH, reg_half);
        end
        PH_W_HIGH: begin
          seq_scl = 1'b0;
          enter_phase(PH_W_HOLD, reg_half);
        end
        PH_W_HOLD: begin
          seq_bits = seq_bits + 4'd1;
          if (seq_bits >= 4'd8) begin
            seq_ph = PH_IDLE;
            fin    = 1'b1;
          end else begin
            shift_out_bit();
          end
        end
        PH_A_REL: begin
          seq_scl = 1'b1;
          seq_ph  = PH_A_POLL;
          seq_tmr = 10'd0;
        end
        PH_R_LOW: begin
          seq_scl   = 1'b1;
          seq_shift = {seq_shift[6:0], sda_in};
          enter_phase(PH_R_HIGH, reg_half);
        end
        PH_R_HIGH: begin
          seq_scl  = 1'b0;
          seq_bits = seq_bits + 4'd1;
          if (seq_bits >= 4'd8) begin
            seq_rx  = seq_shift;
            seq_drv = 1'b1;
            seq_sda = !seq_ack_sel;
            enter_phase(PH_K_LOW, reg_half);
          end else begin
            enter_phase(PH_R_LOW, reg_half);
          end
        end
        PH_K_LOW: begin
          seq_scl = 1'b1;
          enter_phase(PH_K_HIGH, reg_half);
        end
        PH_K_HIGH: begin
          seq_scl = 1'b0;
          seq_ph  = PH_IDLE;
          fin     = 1'b1;
        end
        default: seq_ph = PH_IDLE;
      endcase
    end
    lv.scl  = seq_scl;
    lv.drv  = seq_drv;
    lv.sda  = seq_sda;
    lv.busy = (seq_ph != PH_IDLE);
    lv.done = fin;
    lv.rx   = seq_rx;
    lv.fail = seq_fail;
    return lv;
  endfunction

  function automatic logic pick_sda(input int mode);
    case (mode)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      SDA_RAND: return 1'($urandom);
      default:  return $urandom_range(0, 9) != 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("[%0t] MISMATCH %s: got %0h, expected %0h (result %0d)",
               $realtime, what, got_v, exp_v, n_results);
  endtask

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_tick(input logic [2:0] f, input logic [7:0] tx, input logic ack,
                           input logic sda, input bit typed, input levels_t typed_lv);
    levels_t lv;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_func      = f;
    in_tx_byte   = tx;
    in_send_ack  = ack;
    in_sda_level = sda;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lv = tick_levels(f, tx, ack, sda);
    levels_q.push_back(typed ? typed_lv : lv);
    n_items++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // issue one command, then tick until the sequencer is idle again
  task automatic run_cmd(input logic [2:0] f, input logic [7:0] tx, input logic ack,
                         input int sda_mode, input bit typed = 1'b0,
                         input levels_t typed_lv = '0);
    send_tick(f, tx, ack, pick_sda(sda_mode), typed, typed_lv);
    while (seq_ph != PH_IDLE)
      send_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                pick_sda(sda_mode), 1'b0, '0);
  endtask

  // one command of a transaction, skipped once the item budget is spent
  task automatic budget_cmd(input int item0, input int budget, input logic [2:0] f,
                            input int sda_mode);
    if (n_items - item0 < budget)
      run_cmd(f, 8'($urandom), 1'($urandom), sda_mode);
  endtask

  task automatic wait_drained();
    while (levels_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SETUP: reg_setup = val[7:0];
      CFG_HALF:  reg_half = val[7:0];
      default:   reg_timeout = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] setup, input logic [7:0] half,
                          input logic [9:0] tmo);
    wait_drained();
    write_reg(CFG_SETUP, {2'b00, setup});
    write_reg(CFG_HALF, {2'b00, half});
    write_reg(CFG_TIMEOUT, tmo);
    n_settings++;
  endtask

  // mostly well-formed transactions with random content, some noise
  task automatic random_traffic(input int budget);
    int item0;
    item0 = n_items;
    while (n_items - item0 < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        budget_cmd(item0, budget, CMD_START, SDA_RAND);
        budget_cmd(item0, budget, CMD_WRITE, SDA_RAND);
        budget_cmd(item0, budget, CMD_ACK,
                   $urandom_range(0, 1) ? SDA_RAND : SDA_MOSTLY_HIGH);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1)) begin
            budget_cmd(item0, budget, CMD_WRITE, SDA_RAND);
            budget_cmd(item0, budget, CMD_ACK,
                       $urandom_range(0, 1) ? SDA_RAND : SDA_MOSTLY_HIGH);
          end else begin
            budget_cmd(item0, budget, CMD_READ, SDA_RAND);
          end
        end
        if ($urandom_range(0, 9) != 0)
          budget_cmd(item0, budget, CMD_STOP, SDA_RAND);
      end else begin
        budget_cmd(item0, budget, 3'($urandom_range(0, 7)), SDA_RAND);
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    levels_t got;
    levels_t want;
    if (rst_n && out_valid && out_ready) begin
      got.scl  = out_scl_level;
      got.drv  = out_sda_drive;
      got.sda  = out_sda_out;
      got.busy = out_busy_res;
      got.done = out_done_res;
      got.rx   = out_rx_byte;
      got.fail = out_ack_failed;
      if (levels_q.size() == 0) begin
        report_mismatch("result item with none expected", 1, 0);
      end else begin
        want = levels_q.pop_front();
        if (got.scl !== want.scl) report_mismatch("scl_level", got.scl, want.scl);
        if (got.drv !== want.drv) report_mismatch("sda_drive", got.drv, want.drv);
        if (got.sda !== want.sda) report_mismatch("sda_out", got.sda, want.sda);
        if (got.busy !== want.busy) report_mismatch("busy_res", got.busy, want.busy);
        if (got.done !== want.done) report_mismatch("done_res", got.done, want.done);
        if (got.rx !== want.rx) report_mismatch("rx_byte", got.rx, want.rx);
        if (got.fail !== want.fail) report_mismatch("ack_failed", got.fail, want.fail);
      end
      n_results++;
    end
  end

  initial begin
    #4_000_000;
    $display("Watchdog expired with %0d result items outstanding", levels_q.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int wait_cnt;
    reg_setup   = SETUP_RST;
    reg_half    = HALF_RST;
    reg_timeout = TIMEOUT_RST;
    seq_ph      = PH_IDLE;
    seq_cmd     = CMD_TICK;
    seq_tmr     = '0;
    seq_bits    = '0;
    seq_shift   = '0;
    seq_ack_sel = 1'b0;
    seq_scl     = 1'b1;
    seq_sda     = 1'b1;
    seq_drv     = 1'b1;
    seq_rx      = '0;
    seq_fail    = 1'b0;
    dir_rows = '{
      '{CMD_TICK,   8'h00, 1'b0, SDA_LOW,  1'b1, LV_RESET},
      '{FUNC_RSVD6, 8'hFF, 1'b1, SDA_HIGH, 1'b1, LV_RESET},
      '{FUNC_RSVD7, 8'h80, 1'b1, SDA_LOW,  1'b1, LV_RESET},
      '{CMD_START,  8'h00, 1'b0, SDA_HIGH, 1'b1, LV_START},
      '{CMD_WRITE,  8'hFF, 1'b0, SDA_LOW,  1'b0, '0},
      '{CMD_ACK,    8'h00, 1'b0, SDA_LOW,  1'b0, '0},
      '{CMD_WRITE,  8'h00, 1'b1, SDA_HIGH, 1'b0, '0},
      '{CMD_ACK,    8'h00, 1'b0, SDA_HIGH, 1'b0, '0},
      '{CMD_TICK,   8'h00, 1'b0, SDA_HIGH, 1'b1, LV_ACK_FAIL},
      '{CMD_START,  8'h00, 1'b0, SDA_LOW,  1'b1, LV_START},
      '{CMD_WRITE,  8'hA5, 1'b0, SDA_LOW,  1'b0, '0},
      '{CMD_ACK,    8'h00, 1'b1, SDA_LOW,  1'b0, '0},
      '{CMD_READ,   8'h00, 1'b1, SDA_HIGH, 1'b0, '0},
      '{CMD_READ,   8'hFF, 1'b0, SDA_LOW,  1'b0, '0},
      '{CMD_READ,   8'h5A, 1'b1, SDA_RAND, 1'b0, '0},
      '{CMD_STOP,   8'h00, 1'b0, SDA_HIGH, 1'b0, '0},
      '{CMD_STOP,   8'h00, 1'b1, SDA_LOW,  1'b0, '0},
      '{CMD_WRITE,  8'h01, 1'b0, SDA_LOW,  1'b0, '0},
      '{CMD_TICK,   8'h00, 1'b0, SDA_LOW,  1'b0, '0}
    };

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      run_cmd(dir_rows[i].f, dir_rows[i].tx, dir_rows[i].ack, dir_rows[i].sda_mode,
              dir_rows[i].typed, dir_rows[i].lv);

    // shortest phases, full rate both sides
    set_regs(8'd1, 8'd1, 10'd1);
    random_traffic(RAND_BUDGET);

    // zero lengths and zero timeout, sparse input
    set_regs(8'd0, 8'd0, 10'd0);
    gap_pct = 83;
    random_traffic(RAND_BUDGET);
    gap_pct = 0;

    stall_pct = 83;
    set_regs(8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)), 10'($urandom_range(1, 12)));
    random_traffic(RAND_BUDGET);

    gap_pct   = 21;
    stall_pct = 21;
    set_regs(8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)), 10'($urandom_range(1, 12)));
    hold_req = 1'b1;
    random_traffic(RAND_BUDGET);

    gap_pct   = 0;
    stall_pct = 0;
    wait_cnt  = 0;
    while (levels_q.size() != 0 && wait_cnt < 5000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (8) @(negedge clk);
    if (levels_q.size() != 0)
      report_mismatch("result items never delivered", levels_q.size(), 0);

    $display("Sent %0d tick items (%0d while idle), checked %0d results, %0d register settings.",
             n_items, n_cmd_slots, n_results, n_settings);
    $display("Ack timeouts exercised: %0d; mismatches: %0d.", n_ack_fails, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
